// ===== hdl/ffha_pkg.sv =====
package ffha_pkg;

    localparam int HEAP_WORDS = 512;
    localparam int HDR        = 8;
    localparam int SLACK      = 16;
    localparam int HEAP_BYTES = HEAP_WORDS * HDR;
    localparam int IDX_W      = $clog2(HEAP_WORDS);
    localparam int SIZE_W     = IDX_W + 3;
    localparam int POS_W      = IDX_W + 4;
    localparam int HDR_W      = SIZE_W + 1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_OUTSIDE   = 3'd4,
        ST_DBL_FREE  = 3'd5,
        ST_MID_PTR   = 3'd6
    } t_status;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              occ;
    } t_hdr;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_INIT0,
        OP_INIT1,
        OP_POS_RST,
        OP_FF_TAKE,
        OP_FF_SPLIT,
        OP_ADV,
        OP_FREE_MARK,
        OP_MERGE,
        OP_STEP,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    rd_nxt;
        logic    set_stat;
        t_status stat;
        logic    in_ready;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic too_big;
        logic h0_zero;
        logic addr_out;
        logic aligned_nz;
        logic fit;
        logic adv_end;
        logic match;
        logic rd_occ;
        logic skip_merge;
        logic init_rest;
        logic m_end;
        logic both_free;
        logic clr_last;
        logic out_free;
    } t_flags;

endpackage

// ===== hdl/ffha_intf.sv =====
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [11:0] request_bytes;
    logic [15:0] address;
    modport source (output valid, command, request_bytes, address, input ready);
    modport sink (input valid, command, request_bytes, address, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] payload_offset;
    logic        heap_empty;
    modport source (output valid, status, payload_offset, heap_empty, input ready);
    modport sink (input valid, status, payload_offset, heap_empty, output ready);
endinterface

// ===== hdl/ffha_ram.sv =====
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/ffha_datapath.sv =====
module ffha_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ffha_pkg::t_cmd i_cmd,
    output ffha_pkg::t_flags o_flags,
    ffha_req_if.sink      i_req,
    ffha_rsp_if.source    o_rsp
);
    import ffha_pkg::*;

    logic              r_is_free;
    logic [11:0]       r_req;
    logic [12:0]       r_rnd;
    logic [15:0]       r_addr;
    logic [POS_W-1:0]  r_pos;
    t_hdr              r_cur;
    t_hdr              r_h0;
    logic [SIZE_W-1:0] r_rest;
    t_status           r_stat;
    logic [11:0]       r_off;
    logic              r_ov;
    t_status           r_o_stat;
    logic [11:0]       r_o_off;
    logic              r_o_empty;

    t_hdr              rd;
    logic              we;
    logic [IDX_W-1:0]  widx;
    t_hdr              wdata;
    logic [IDX_W-1:0]  raddr;
    logic [SIZE_W-1:0] rsz;
    logic [POS_W-1:0]  adv;
    logic [POS_W-1:0]  nxt;
    logic [POS_W-1:0]  init_pos;
    logic [POS_W-1:0]  split_pos;
    logic [IDX_W-1:0]  pos_idx;
    logic [12:0]       rnd_in;
    logic              empty;

    assign rsz       = SIZE_W'(r_rnd);
    assign pos_idx   = r_pos[IDX_W+2:3];
    assign adv       = r_pos + POS_W'(HDR) + POS_W'(rd.size);
    assign nxt       = r_pos + POS_W'(HDR) + POS_W'(r_cur.size);
    assign init_pos  = POS_W'(HDR) + POS_W'(rsz);
    assign split_pos = r_pos + POS_W'(HDR) + POS_W'(rsz);
    assign raddr     = i_cmd.rd_nxt ? nxt[IDX_W+2:3] : pos_idx;
    assign rnd_in    = ({1'b0, i_req.request_bytes} + 13'd7) & ~13'd7;
    assign empty     = (r_h0.size == '0) ||
                       (!r_h0.occ && 32'(r_h0.size) == HEAP_BYTES - HDR);

    ffha_ram #(.WIDTH(HDR_W), .DEPTH(HEAP_WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (widx),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    always_comb begin
        we    = 1'b0;
        widx  = pos_idx;
        wdata = '0;
        case (i_cmd.op)
            OP_CLEAR: begin
                we = 1'b1;
            end
            OP_INIT0: begin
                we    = 1'b1;
                widx  = '0;
                wdata = '{size: rsz, occ: 1'b1};
            end
            OP_INIT1: begin
                we    = 1'b1;
                widx  = init_pos[IDX_W+2:3];
                wdata = '{size: SIZE_W'(HEAP_BYTES - SLACK) - rsz, occ: 1'b0};
            end
            OP_FF_TAKE: begin
                we    = 1'b1;
                wdata = '{size: rsz, occ: 1'b1};
            end
            OP_FF_SPLIT: begin
                we    = 1'b1;
                widx  = split_pos[IDX_W+2:3];
                wdata = '{size: r_rest, occ: 1'b0};
            end
            OP_FREE_MARK: begin
                we    = 1'b1;
                wdata = '{size: rd.size, occ: 1'b0};
            end
            OP_MERGE: begin
                we    = 1'b1;
                wdata = '{size: r_cur.size + SIZE_W'(HDR) + rd.size, occ: 1'b0};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_h0  <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (we && widx == '0) begin
                r_h0 <= wdata;
            end
            if (i_cmd.op == OP_PUSH) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLEAR:   r_pos <= r_pos + POS_W'(HDR);
                OP_POS_RST: r_pos <= '0;
                OP_ADV:     r_pos <= adv;
                OP_STEP:    r_pos <= nxt;
                default:    r_pos <= r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_stat) begin
            r_stat <= i_cmd.stat;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_is_free <= i_req.command;
                r_req     <= i_req.request_bytes;
                r_rnd     <= rnd_in;
                r_addr    <= i_req.address;
                r_stat    <= ST_OK;
                r_off     <= '0;
            end
            OP_INIT0: begin
                r_off <= 12'(HDR);
            end
            OP_POS_RST: begin
                r_cur <= r_h0;
            end
            OP_FF_TAKE: begin
                r_rest <= rd.size - SIZE_W'(HDR) - rsz;
                r_off  <= 12'(r_pos + POS_W'(HDR));
            end
            OP_MERGE: begin
                r_cur.size <= r_cur.size + SIZE_W'(HDR) + rd.size;
            end
            OP_STEP: begin
                r_cur <= rd;
            end
            OP_PUSH: begin
                r_o_stat  <= r_stat;
                r_o_off   <= r_off;
                r_o_empty <= empty;
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

    assign i_req.ready          = i_cmd.in_ready;
    assign o_rsp.valid          = r_ov;
    assign o_rsp.status         = r_o_stat;
    assign o_rsp.payload_offset = r_o_off;
    assign o_rsp.heap_empty     = r_o_empty;

    assign o_flags.is_free    = r_is_free;
    assign o_flags.req_zero   = (r_req == '0);
    assign o_flags.too_big    = 32'(r_rnd) > HEAP_BYTES - HDR;
    assign o_flags.h0_zero    = (r_h0.size == '0);
    assign o_flags.addr_out   = 32'(r_addr) >= HEAP_BYTES;
    assign o_flags.aligned_nz = (r_addr != '0) && (r_addr[2:0] == 3'd0);
    assign o_flags.fit        = !rd.occ &&
                                (POS_W'(rd.size) >= POS_W'(rsz) + POS_W'(SLACK));
    assign o_flags.adv_end    = 32'(adv) >= HEAP_BYTES;
    assign o_flags.match      = (32'(r_pos) + HDR) == 32'(r_addr);
    assign o_flags.rd_occ     = rd.occ;
    assign o_flags.skip_merge = 32'(r_h0.size) >= HEAP_BYTES - HDR;
    assign o_flags.init_rest  = 32'(r_rnd) < HEAP_BYTES - SLACK;
    assign o_flags.m_end      = 32'(nxt) >= HEAP_BYTES;
    assign o_flags.both_free  = !r_cur.occ && !rd.occ;
    assign o_flags.clr_last   = (pos_idx == IDX_W'(HEAP_WORDS - 1));
    assign o_flags.out_free   = !r_ov || o_rsp.ready;
endmodule

// ===== hdl/ffha_ctrl.sv =====
module ffha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ffha_pkg::t_flags i_flags,
    output ffha_pkg::t_cmd   o_cmd
);
    import ffha_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DECODE   = 13'b0000000000100,
        S_INIT1    = 13'b0000000001000,
        S_FF_RD    = 13'b0000000010000,
        S_FF_EV    = 13'b0000000100000,
        S_FF_SPLIT = 13'b0000001000000,
        S_RL_RD    = 13'b0000010000000,
        S_RL_EV    = 13'b0000100000000,
        S_M_START  = 13'b0001000000000,
        S_M_CHK    = 13'b0010000000000,
        S_M_EV     = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.rd_nxt   = 1'b0;
        o_cmd.set_stat = 1'b0;
        o_cmd.stat     = ST_OK;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_flags.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_stat = 1'b1;
                n_state        = S_DONE;
                if (!i_flags.is_free) begin
                    if (i_flags.req_zero) begin
                        o_cmd.stat = ST_ZERO;
                    end else if (i_flags.too_big) begin
                        o_cmd.stat = ST_TOO_LARGE;
                    end else if (i_flags.h0_zero) begin
                        o_cmd.op = OP_INIT0;
                        if (i_flags.init_rest) n_state = S_INIT1;
                    end else begin
                        o_cmd.op = OP_POS_RST;
                        n_state  = S_FF_RD;
                    end
                end else begin
                    if (i_flags.addr_out) begin
                        o_cmd.stat = ST_OUTSIDE;
                    end else if (i_flags.h0_zero) begin
                        o_cmd.stat = i_flags.aligned_nz ? ST_DBL_FREE : ST_MID_PTR;
                    end else begin
                        o_cmd.op = OP_POS_RST;
                        n_state  = S_RL_RD;
                    end
                end
            end
            S_INIT1: begin
                o_cmd.op = OP_INIT1;
                n_state  = S_DONE;
            end
            S_FF_RD: begin
                n_state = S_FF_EV;
            end
            S_FF_EV: begin
                if (i_flags.fit) begin
                    o_cmd.op = OP_FF_TAKE;
                    n_state  = S_FF_SPLIT;
                end else begin
                    o_cmd.op = OP_ADV;
                    if (i_flags.adv_end) begin
                        o_cmd.set_stat = 1'b1;
                        o_cmd.stat     = ST_NO_SPACE;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_FF_RD;
                    end
                end
            end
            S_FF_SPLIT: begin
                o_cmd.op = OP_FF_SPLIT;
                n_state  = S_DONE;
            end
            S_RL_RD: begin
                n_state = S_RL_EV;
            end
            S_RL_EV: begin
                if (i_flags.match) begin
                    o_cmd.set_stat = 1'b1;
                    n_state        = S_M_START;
                    if (i_flags.rd_occ) begin
                        o_cmd.op = OP_FREE_MARK;
                    end else begin
                        o_cmd.stat = ST_DBL_FREE;
                    end
                end else begin
                    o_cmd.op = OP_ADV;
                    if (i_flags.adv_end) begin
                        o_cmd.set_stat = 1'b1;
                        o_cmd.stat     = ST_MID_PTR;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_RL_RD;
                    end
                end
            end
            S_M_START: begin
                if (i_flags.skip_merge) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_POS_RST;
                    n_state  = S_M_CHK;
                end
            end
            S_M_CHK: begin
                o_cmd.rd_nxt = 1'b1;
                n_state      = i_flags.m_end ? S_DONE : S_M_EV;
            end
            S_M_EV: begin
                o_cmd.op = i_flags.both_free ? OP_MERGE : OP_STEP;
                n_state  = S_M_CHK;
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    o_cmd.op = OP_PUSH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end
endmodule

// ===== hdl/first_fit_heap_allocator_top.sv =====
// channel  | dir | transfer payload
// i_req    | in  | command, request_bytes, address
// o_rsp    | out | status, payload_offset, heap_empty
//
// After reset all 512 header words are swept to zero, with i_req.ready low.
// Each header visit takes a read state and an evaluate state (RAM read is registered);
// a free may add a coalescing walk from the heap start after its search walk.
// One item is worked at a time; i_req.ready is high only when the sequencer is idle.
// A finished result sits in the output register; while o_rsp is stalled the next result waits in S_DONE.
module first_fit_heap_allocator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);
    import ffha_pkg::*;

    t_cmd   cmd;
    t_flags flags;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    ffha_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_flags (flags),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("accepted a second item while busy");

    a_offset_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.payload_offset[2:0] == 3'd0))
        else $error("payload offset not 8-byte aligned");

    a_fail_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.payload_offset == 12'd0))
        else $error("failed request reports an offset");
endmodule
